// ===== hw/rtl/acpu_pkg.sv =====
package acpu_pkg;

    localparam int DEF_DATA_WORDS = 128;
    localparam int DEF_CODE_WORDS = 256;
    localparam int QUEUE_DEPTH    = 2;
    localparam int PC_OUT_W       = 8;

    localparam logic [3:0] OP_HLT = 4'd0;
    localparam logic [3:0] OP_IN  = 4'd1;
    localparam logic [3:0] OP_OUT = 4'd2;
    localparam logic [3:0] OP_LDA = 4'd3;
    localparam logic [3:0] OP_STA = 4'd4;
    localparam logic [3:0] OP_ADD = 4'd5;
    localparam logic [3:0] OP_SUB = 4'd6;
    localparam logic [3:0] OP_INC = 4'd7;
    localparam logic [3:0] OP_DEC = 4'd8;
    localparam logic [3:0] OP_JMP = 4'd9;
    localparam logic [3:0] OP_JZ  = 4'd10;
    localparam logic [3:0] OP_JN  = 4'd11;
    localparam logic [3:0] OP_LIT = 4'd12;

    typedef struct packed {
        logic [3:0]         opcode;
        logic signed [15:0] operand;
        logic signed [15:0] in_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         next_pc;
        logic signed [15:0] acc_value;
        logic               out_valid;
        logic signed [15:0] out_value;
        logic               halted;
        logic               illegal_op;
    } t_out_item;

    typedef enum logic [3:0] {
        EX_HLT, EX_IN, EX_OUT, EX_LDA, EX_STA, EX_ADD, EX_SUB,
        EX_INC, EX_DEC, EX_JMP, EX_JZ, EX_JN, EX_LIT, EX_ILL
    } t_exec_op;

    // quotient estimates feed the modulo reduction in the back end
    typedef struct packed {
        t_exec_op    op;
        logic [15:0] operand;
        logic [15:0] in_value;
        logic [15:0] data_quot;
        logic [15:0] code_quot;
    } t_dec_item;

endpackage

// ===== hw/rtl/acpu_front.sv =====
module acpu_front #(
    parameter int DATA_WORDS = acpu_pkg::DEF_DATA_WORDS,
    parameter int CODE_WORDS = acpu_pkg::DEF_CODE_WORDS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  acpu_pkg::t_in_item  i_data,
    output logic                o_full,
    output logic                o_valid,
    output acpu_pkg::t_dec_item o_item,
    input  logic                i_take
);
    import acpu_pkg::*;

    // reciprocal constants: q = (x * M) >> S is exact or one low for 16-bit x
    localparam int          DS    = 16 + $clog2(DATA_WORDS);
    localparam int          CS    = 16 + $clog2(CODE_WORDS);
    localparam logic [16:0] DM    = 17'((64'd1 << DS) / DATA_WORDS);
    localparam logic [16:0] CM    = 17'((64'd1 << CS) / CODE_WORDS);
    localparam int          PTR_W = $clog2(QUEUE_DEPTH);
    localparam int          CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [32:0]  d_prod;
    logic [32:0]  c_prod;
    t_exec_op     dec_op;
    t_dec_item    dec_item;

    t_dec_item        r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        case (i_data.opcode)
            OP_HLT:  dec_op = EX_HLT;
            OP_IN:   dec_op = EX_IN;
            OP_OUT:  dec_op = EX_OUT;
            OP_LDA:  dec_op = EX_LDA;
            OP_STA:  dec_op = EX_STA;
            OP_ADD:  dec_op = EX_ADD;
            OP_SUB:  dec_op = EX_SUB;
            OP_INC:  dec_op = EX_INC;
            OP_DEC:  dec_op = EX_DEC;
            OP_JMP:  dec_op = EX_JMP;
            OP_JZ:   dec_op = EX_JZ;
            OP_JN:   dec_op = EX_JN;
            OP_LIT:  dec_op = EX_LIT;
            default: dec_op = EX_ILL;
        endcase
    end

    assign d_prod = 33'($unsigned(i_data.operand)) * 33'(DM);
    assign c_prod = 33'($unsigned(i_data.operand)) * 33'(CM);

    always_comb begin
        dec_item.op        = dec_op;
        dec_item.operand   = $unsigned(i_data.operand);
        dec_item.in_value  = $unsigned(i_data.in_value);
        dec_item.data_quot = 16'(d_prod >> DS);
        dec_item.code_quot = 16'(c_prod >> CS);
    end

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_take ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push) - CNT_W'(i_take);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= dec_item;
        end
    end

endmodule

// ===== hw/rtl/acpu_back.sv =====
module acpu_back #(
    parameter int DATA_WORDS = acpu_pkg::DEF_DATA_WORDS,
    parameter int CODE_WORDS = acpu_pkg::DEF_CODE_WORDS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  acpu_pkg::t_dec_item i_item,
    output logic                o_take,
    output logic                o_busy,
    output logic                o_res_valid,
    output acpu_pkg::t_out_item o_res,
    input  logic                i_pop
);
    import acpu_pkg::*;

    localparam int AW  = $clog2(DATA_WORDS);
    localparam int PW  = $clog2(CODE_WORDS);
    localparam int PCW = (PW > PC_OUT_W) ? PW : PC_OUT_W;
    localparam logic [16:0] DW_L  = 17'(DATA_WORDS);
    localparam logic [16:0] CW_L  = 17'(CODE_WORDS);
    localparam logic [PCW:0] CW_P = (PCW + 1)'(CODE_WORDS);

    // data memory and zeroing sweep
    logic [15:0]   r_mem [DATA_WORDS];
    logic [15:0]   r_rdata;
    logic          r_clearing;
    logic [AW-1:0] r_clr_idx;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;

    // stage 1: address reduction and memory read
    logic [16:0]    d_diff;
    logic [16:0]    d_rem;
    logic [16:0]    c_diff;
    logic [16:0]    c_rem;
    logic [AW-1:0]  s1_addr;

    // stage 2: execute
    logic           r_s2_v;
    t_exec_op       r_s2_op;
    logic [15:0]    r_s2_operand;
    logic [15:0]    r_s2_in_value;
    logic [PCW-1:0] r_s2_target;
    logic [AW-1:0]  r_s2_addr;
    logic           r_fwd;
    logic [15:0]    r_fwd_data;
    logic           s2_fire;
    logic           s2_ready;

    logic [15:0]    r_acc;
    logic [15:0]    n_acc;
    logic [PCW-1:0] r_pc;
    logic [PCW-1:0] n_pc;
    logic           r_stopped;
    logic           n_stopped;
    logic [PCW:0]   pc_sum;
    logic [PCW-1:0] pc_seq;
    logic [15:0]    mem_val;
    logic           ex_we;
    logic [15:0]    ex_wdata;
    logic           ex_out_valid;
    logic [15:0]    ex_out_value;
    logic           ex_illegal;

    t_out_item      r_res;
    logic           r_res_v;

    assign s2_fire  = r_s2_v && (!r_res_v || i_pop);
    assign s2_ready = !r_s2_v || s2_fire;
    assign o_take   = i_valid && s2_ready;
    assign o_busy   = r_clearing;

    always_comb begin
        d_diff  = {1'b0, i_item.operand} - 17'(i_item.data_quot * DW_L);
        d_rem   = (d_diff >= DW_L) ? d_diff - DW_L : d_diff;
        c_diff  = {1'b0, i_item.operand} - 17'(i_item.code_quot * CW_L);
        c_rem   = (c_diff >= CW_L) ? c_diff - CW_L : c_diff;
        s1_addr = d_rem[AW-1:0];
    end

    assign mem_we    = r_clearing || (s2_fire && ex_we);
    assign mem_waddr = r_clearing ? r_clr_idx : r_s2_addr;
    assign mem_wdata = r_clearing ? 16'd0 : ex_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (o_take) begin
            r_rdata <= r_mem[s1_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == AW'(DATA_WORDS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // read-during-write of the same word returns old data: bypass it
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_s2_op       <= i_item.op;
            r_s2_operand  <= i_item.operand;
            r_s2_in_value <= i_item.in_value;
            r_s2_target   <= PCW'(c_rem);
            r_s2_addr     <= s1_addr;
            r_fwd         <= s2_fire && ex_we && (r_s2_addr == s1_addr);
            r_fwd_data    <= ex_wdata;
        end
    end

    assign mem_val = r_fwd ? r_fwd_data : r_rdata;

    always_comb begin
        pc_sum = {1'b0, r_pc} + (PCW + 1)'(2);
        if (pc_sum >= CW_P) begin
            pc_sum = pc_sum - CW_P;
        end
        pc_seq = pc_sum[PCW-1:0];
    end

    always_comb begin
        n_acc        = r_acc;
        n_pc         = r_pc;
        n_stopped    = r_stopped;
        ex_we        = 1'b0;
        ex_wdata     = r_acc;
        ex_out_valid = 1'b0;
        ex_out_value = 16'd0;
        ex_illegal   = 1'b0;
        if (!r_stopped) begin
            case (r_s2_op)
                EX_HLT: begin
                    n_stopped = 1'b1;
                end
                EX_IN: begin
                    n_acc = r_s2_in_value;
                    n_pc  = pc_seq;
                end
                EX_OUT: begin
                    ex_out_valid = 1'b1;
                    ex_out_value = r_acc;
                    n_pc         = pc_seq;
                end
                EX_LDA: begin
                    n_acc = mem_val;
                    n_pc  = pc_seq;
                end
                EX_STA: begin
                    ex_we    = 1'b1;
                    ex_wdata = r_acc;
                    n_pc     = pc_seq;
                end
                EX_ADD: begin
                    n_acc = r_acc + mem_val;
                    n_pc  = pc_seq;
                end
                EX_SUB: begin
                    n_acc = r_acc - mem_val;
                    n_pc  = pc_seq;
                end
                EX_INC: begin
                    ex_we    = 1'b1;
                    ex_wdata = mem_val + 16'd1;
                    n_pc     = pc_seq;
                end
                EX_DEC: begin
                    ex_we    = 1'b1;
                    ex_wdata = mem_val - 16'd1;
                    n_pc     = pc_seq;
                end
                EX_JMP: begin
                    n_pc = r_s2_target;
                end
                EX_JZ: begin
                    n_pc = (r_acc == 16'd0) ? r_s2_target : pc_seq;
                end
                EX_JN: begin
                    n_pc = r_acc[15] ? r_s2_target : pc_seq;
                end
                EX_LIT: begin
                    n_acc = r_s2_operand;
                    n_pc  = pc_seq;
                end
                EX_ILL: begin
                    n_stopped  = 1'b1;
                    ex_illegal = 1'b1;
                end
                default: begin
                    n_stopped  = 1'b1;
                    ex_illegal = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v    <= 1'b0;
            r_res_v   <= 1'b0;
            r_acc     <= '0;
            r_pc      <= '0;
            r_stopped <= 1'b0;
        end else begin
            if (o_take) begin
                r_s2_v <= 1'b1;
            end else if (s2_fire) begin
                r_s2_v <= 1'b0;
            end
            if (s2_fire) begin
                r_res_v   <= 1'b1;
                r_acc     <= n_acc;
                r_pc      <= n_pc;
                r_stopped <= n_stopped;
            end else if (i_pop) begin
                r_res_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_res.next_pc    <= n_pc[PC_OUT_W-1:0];
            r_res.acc_value  <= $signed(n_acc);
            r_res.out_valid  <= ex_out_valid;
            r_res.out_value  <= $signed(ex_out_value);
            r_res.halted     <= n_stopped;
            r_res.illegal_op <= ex_illegal;
        end
    end

    assign o_res_valid = r_res_v;
    assign o_res       = r_res;

endmodule

// ===== hw/rtl/accumulator_cpu_execute_unit.sv =====
// Taken instructions are registered in stage 2, their results in the result register.
// One instruction per cycle while results pop; stores forward into the next load.
// Reset: accumulator, PC and halt flag clear at once; the data memory is then
// zeroed one word a cycle, with full held high meanwhile.
// The data memory port (one write, one registered read) sets the two-stage back end.
module accumulator_cpu_execute_unit #(
    parameter int DATA_WORDS = acpu_pkg::DEF_DATA_WORDS,
    parameter int CODE_WORDS = acpu_pkg::DEF_CODE_WORDS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  acpu_pkg::t_in_item  i_data,
    output logic                empty,
    input  logic                pop,
    output acpu_pkg::t_out_item o_data
);
    import acpu_pkg::*;

    logic      q_full;
    logic      q_valid;
    t_dec_item q_item;
    logic      q_take;
    logic      busy;
    logic      res_valid;
    logic      push_ok;

    assign full    = q_full || busy;
    assign push_ok = push && !full;
    assign empty   = !res_valid;

    acpu_front #(
        .DATA_WORDS (DATA_WORDS),
        .CODE_WORDS (CODE_WORDS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_ok),
        .i_data  (i_data),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_take  (q_take)
    );

    acpu_back #(
        .DATA_WORDS (DATA_WORDS),
        .CODE_WORDS (CODE_WORDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_take      (q_take),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (o_data),
        .i_pop       (pop && res_valid)
    );

endmodule
